### hw/rtl/wlsq_pkg.sv
// Shared constants, widths and result packing for the weight-limited slot queue.
// No dependencies; the slot queue imports this package, wlsq_ram does not.
`default_nettype none

package wlsq_pkg;

    localparam int SLOTS       = 8;
    localparam int PTR_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int MASS_W      = 16;
    localparam int LOAD_W      = 19;
    localparam logic [LOAD_W-1:0] LIMIT_RESET = 19'd524280;

    // result word: accepted, taken_mass, item_waiting, total_load (LSB first)
    localparam int RES_W       = 1 + MASS_W + 1 + LOAD_W;
    localparam int M_TDATA_W   = ((RES_W + 7) / 8) * 8;

    typedef logic [M_TDATA_W-1:0] res_word_t;

    function automatic res_word_t pack_result(
        input logic              ok,
        input logic [MASS_W-1:0] taken,
        input logic              waiting,
        input logic [LOAD_W-1:0] load
    );
        res_word_t w;
        w = '0;
        w[0]                            = ok;
        w[MASS_W:1]                     = taken;
        w[MASS_W+1]                     = waiting;
        w[MASS_W+1+LOAD_W:MASS_W+2]     = load;
        return w;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/wlsq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module wlsq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/weight_limited_slot_queue.sv
// Weight-limited slot queue: FIFO of item masses in a slot RAM, admission by total mass.
// Offer: the result goes straight from the input transaction into the output register.
// Take: registered read of the slot RAM at the head pointer (ST_READ), then the output register.
// Throughput: one offer per cycle unless the output stalls or a take is in ST_READ.
// Reset (rst_n, async low): empty queue, total zero, mass_limit = 524280; RAM not cleared.
// Depends on wlsq_pkg and wlsq_ram.
`default_nettype none

module weight_limited_slot_queue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration: mass_limit
    input  wire logic                           cfg_we,
    input  wire logic [wlsq_pkg::LOAD_W-1:0]    cfg_data,
    // request channel
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [wlsq_pkg::MASS_W-1:0]    s_tdata,   // [15:0] item_mass
    input  wire logic                           s_tuser,   // mode: 0 offer, 1 take
    // result channel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [wlsq_pkg::M_TDATA_W-1:0]      m_tdata    // [0] accepted, [16:1] taken_mass,
                                                           // [17] item_waiting,
                                                           // [36:18] total_load, rest zero
);

    import wlsq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;   // waiting on slot RAM read for a take

    // control state
    logic              state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [LOAD_W-1:0] load_reg, load_next;
    logic [LOAD_W-1:0] limit_reg;
    logic              out_valid_reg, out_valid_next;
    res_word_t         out_data_reg, out_data_next;

    logic              accept;
    logic              offer_ok;
    logic              take_go;
    logic [LOAD_W:0]   offer_sum;
    logic [MASS_W-1:0] rd_mass;
    logic [LOAD_W-1:0] rd_mass_ext;
    logic [LOAD_W-1:0] take_load;
    logic [CNT_W-1:0]  occ_dec;

    // Accept only in idle, and only if the output register is free by the next edge.
    // A take blocks further requests until its RAM read returns.
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign offer_sum = {1'b0, load_reg} + {{(LOAD_W + 1 - MASS_W){1'b0}}, s_tdata};

    // Offer needs a free slot, nonzero mass and room under the limit.
    assign offer_ok = !s_tuser
                   && (occ_reg < CNT_W'(SLOTS))
                   && (s_tdata != '0)
                   && (offer_sum <= {1'b0, limit_reg});

    // Take with items present goes to the RAM; an empty take answers at once.
    assign take_go = accept && s_tuser && (occ_reg != '0);

    // Slot store: written at tail on an admitted offer, read at head on a take.
    // Write and read never fall in the same cycle for a take that depends on the write,
    // since a take is launched no earlier than the edge after the write.
    wlsq_ram #(
        .WIDTH (MASS_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (accept && offer_ok),
        .waddr (tail_reg),
        .wdata (s_tdata),
        .re    (take_go),
        .raddr (head_reg),
        .rdata (rd_mass)
    );

    assign rd_mass_ext = {{(LOAD_W - MASS_W){1'b0}}, rd_mass};
    assign take_load   = (load_reg >= rd_mass_ext) ? (load_reg - rd_mass_ext) : '0;
    assign occ_dec     = occ_reg - CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        load_next      = load_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (take_go)
                begin
                    state_next = ST_READ;
                end
                else if (accept)
                begin
                    out_valid_next = 1'b1;
                    if (offer_ok)
                    begin
                        tail_next     = (tail_reg == PTR_W'(SLOTS - 1)) ? '0
                                                                         : tail_reg + PTR_W'(1);
                        occ_next      = occ_reg + CNT_W'(1);
                        load_next     = offer_sum[LOAD_W-1:0];
                        out_data_next = pack_result(1'b1, '0, 1'b1, offer_sum[LOAD_W-1:0]);
                    end
                    else
                    begin
                        // refused offer or take from an empty queue: state unchanged
                        out_data_next = pack_result(1'b0, '0, (occ_reg != '0), load_reg);
                    end
                end
            end
            ST_READ:
            begin
                state_next     = ST_IDLE;
                head_next      = (head_reg == PTR_W'(SLOTS - 1)) ? '0 : head_reg + PTR_W'(1);
                occ_next       = occ_dec;
                load_next      = take_load;
                out_valid_next = 1'b1;
                out_data_next  = pack_result(1'b1, rd_mass, (occ_dec != '0), take_load);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            load_reg      <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            load_reg      <= load_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // result payload register, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------

    // occupancy never passes the slot count
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(SLOTS))
        else $error("occupancy above slot count");

    // masses are nonzero, so an empty queue carries no load and vice versa
    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) == (load_reg == '0))
        else $error("load and occupancy disagree");

    // output register is always free while a take waits on the RAM
    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !out_valid_reg)
        else $error("take result would overwrite pending result");

    // a launched take always prepares an accepted result for the output register in ST_READ
    a_take_result: assert property (@(posedge clk) disable iff (!rst_n)
        take_go |=> (out_valid_next && out_data_next[0]))
        else $error("take lost its result");

endmodule

`default_nettype wire
